// File: rtl/three_channel_light_fader_assert.svh
// Assertion macros for the three-channel light fader.
// Expects signals named clk and rst_n in the including module.
`ifndef THREE_CHANNEL_LIGHT_FADER_ASSERT_SVH
`define THREE_CHANNEL_LIGHT_FADER_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define TCLF_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold in the clock cycle after a trigger.
`define TCLF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tclf_pkg.sv
// Shared types and constants of the three-channel light fader.
// No dependencies; used by the sequencer and the top level.
package tclf_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_FADE_RATE     = 3'd0;
  localparam logic [2:0] REG_MAX_INTENSITY = 3'd1;
  localparam logic [2:0] REG_COLOR_ONE     = 3'd2;
  localparam logic [2:0] REG_COLOR_TWO     = 3'd3;
  localparam logic [2:0] REG_COLOR_THREE   = 3'd4;
  localparam logic [2:0] REG_HOLD_FIXED    = 3'd5;

  // Channel and color slot indexes used by the sequencer.
  localparam logic [1:0] CH_FIRST   = 2'd0;
  localparam logic [1:0] CH_LAST    = 2'd2;
  localparam logic [1:0] SLOT_RED   = 2'd2;
  localparam logic [1:0] SLOT_GREEN = 2'd1;
  localparam logic [1:0] SLOT_BLUE  = 2'd0;

  // Phases of the per-item sequence around the shared multiplier.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAC_MUL,
    ST_FRAC_SET,
    ST_MOVE_MUL,
    ST_MOVE_STEP,
    ST_MOVE_APPLY,
    ST_SUM,
    ST_INT_MUL,
    ST_INT_SET,
    ST_MIX_MUL,
    ST_MIX_ACC,
    ST_DONE
  } state_t;

  // Control word from the sequencer to the datapath.
  typedef struct packed {
    state_t     phase;
    logic [1:0] ch;
    logic [1:0] slot;
  } ctrl_t;

endpackage

// File: rtl/tclf_mul.sv
// Shared registered multiplier of the three-channel light fader.
// Standalone; instantiated by the top level.
module tclf_mul #(
  parameter int AW = 16,
  parameter int BW = 16
) (
  input  logic             clk,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] prod
);

  logic [AW+BW-1:0] prod_r;

  // Product is registered so the consumer sees it in the cycle after the operands.
  always_ff @(posedge clk) begin
    prod_r <= (AW+BW)'(a) * (AW+BW)'(b);
  end

  assign prod = prod_r;

endmodule

// File: rtl/tclf_seq.sv
// Sequencer of the three-channel light fader.
// Depends on tclf_pkg; steps the datapath through one item's work.
module tclf_seq
  import tclf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  out_free,
  output ctrl_t ctrl
);

  state_t     state_r, state_nxt;
  logic [1:0] ch_r, ch_nxt;
  logic [1:0] slot_r, slot_nxt;

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= CH_FIRST;
      slot_r  <= SLOT_RED;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // Next state: fraction, three level moves, level sum, intensity, nine mix products.
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    slot_nxt  = slot_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_FRAC_MUL;
        end
        ch_nxt   = CH_FIRST;
        slot_nxt = SLOT_RED;
      end
      ST_FRAC_MUL:  state_nxt = ST_FRAC_SET;
      ST_FRAC_SET:  state_nxt = ST_MOVE_MUL;
      ST_MOVE_MUL:  state_nxt = ST_MOVE_STEP;
      ST_MOVE_STEP: state_nxt = ST_MOVE_APPLY;
      ST_MOVE_APPLY: begin
        if (ch_r == CH_LAST) begin
          ch_nxt    = CH_FIRST;
          state_nxt = ST_SUM;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = ST_MOVE_MUL;
        end
      end
      ST_SUM:      state_nxt = ST_INT_MUL;
      ST_INT_MUL:  state_nxt = ST_INT_SET;
      ST_INT_SET:  state_nxt = ST_MIX_MUL;
      ST_MIX_MUL:  state_nxt = ST_MIX_ACC;
      ST_MIX_ACC: begin
        state_nxt = ST_MIX_MUL;
        if (ch_r == CH_LAST) begin
          ch_nxt = CH_FIRST;
          if (slot_r == SLOT_BLUE) begin
            state_nxt = ST_DONE;
          end else begin
            slot_nxt = slot_r - 2'd1;
          end
        end else begin
          ch_nxt = ch_r + 2'd1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign ctrl.phase = state_r;
  assign ctrl.ch    = ch_r;
  assign ctrl.slot  = slot_r;

endmodule

// File: rtl/three_channel_light_fader.sv
// Three-channel light fader: input item of three targets and elapsed time,
// result item of intensity and red, green, blue.
// Input channel: in_valid / in_stall; an item is taken when in_valid is high
// and in_stall is low. Result channel: out_valid / out_stall, same rule.
// Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data; cfg_ready
// is always high. Write registers only while the block is idle.
// Items: an item whose clamped targets all equal the current levels (or any
// item in hold mode) is consumed without leaving the idle phase and gives no
// result. Any other item occupies the block until its result is registered.
// The length of that sequence is set by the single shared multiplier, which performs the
// fraction, three level steps, the intensity and nine color products in turn.
// Back-pressure: a finished result waits in the output register while the
// next item is accepted; the block holds in its final phase only if an
// older result is still stalled there.
// Reset: levels return to zero, registers to their defaults, no result pending.
`include "three_channel_light_fader_assert.svh"

module three_channel_light_fader
  import tclf_pkg::*;
#(
  parameter int LEVEL_FRAC_BITS = 16,
  parameter int COLOR_BITS      = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [LEVEL_FRAC_BITS:0]     in_target_one,
  input  logic [LEVEL_FRAC_BITS:0]     in_target_two,
  input  logic [LEVEL_FRAC_BITS:0]     in_target_three,
  input  logic [15:0]                  in_elapsed,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [15:0]                  out_intensity,
  output logic [COLOR_BITS-1:0]        out_red,
  output logic [COLOR_BITS-1:0]        out_green,
  output logic [COLOR_BITS-1:0]        out_blue,
  // Configuration write channel.
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [2:0]                   cfg_index,
  input  logic [((3*COLOR_BITS > 16) ? 3*COLOR_BITS : 16)-1:0] cfg_data
);

  localparam int LW  = LEVEL_FRAC_BITS + 1;
  localparam int CW  = 3 * COLOR_BITS;
  localparam int OW  = (LW > 16) ? LW : 16;
  localparam int PW  = 2 * OW;
  localparam int ACW = COLOR_BITS + LEVEL_FRAC_BITS + 2;
  localparam int SH  = 24 - LEVEL_FRAC_BITS;
  localparam logic [LW-1:0]         ONE   = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};
  localparam logic [31:0]           ONE_W = 32'(ONE);
  localparam logic [COLOR_BITS+1:0] CMAX  = {2'b00, {COLOR_BITS{1'b1}}};

  // Configuration registers.
  logic [15:0]   fade_rate_r;
  logic [15:0]   max_intensity_r;
  logic [CW-1:0] color_r [3];
  logic          hold_fixed_r;

  // Per-item working registers.
  logic [LW-1:0] lvl_r [3];
  logic [LW-1:0] mag_r [3];
  logic          up_r [3];
  logic [15:0]   elapsed_r;
  logic [LW-1:0] frac_r;
  logic [LW-1:0] step_r;
  logic [LW-1:0] sum_r;
  logic [ACW-1:0] acc_r;
  logic [15:0]   int_r;
  logic [COLOR_BITS-1:0] mix_r [3];

  // Result register.
  logic                  out_valid_r;
  logic [15:0]           out_int_r;
  logic [COLOR_BITS-1:0] out_red_r, out_green_r, out_blue_r;

  ctrl_t          ctrl;
  logic           accept, start, out_free, load_out;
  logic [LW-1:0]  tgt [3];
  logic [LW-1:0]  mag_in [3];
  logic           up_in [3];
  logic           any_diff;
  logic [OW-1:0]  mul_a, mul_b;
  logic [PW-1:0]  prod;
  logic [31:0]    frac_full;
  logic [LW:0]    step_ceil;
  logic [LW+1:0]  lvl_sum;
  logic [ACW-1:0] acc_nxt;
  logic [COLOR_BITS+1:0] mix_hi;

  // Terms checked by the assertions.
  logic           lvl_ok;
  logic           step_ok;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign in_stall  = (ctrl.phase != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = (ctrl.phase == ST_DONE) && out_free;

  // Clamp the targets to one and find each channel's distance and direction.
  assign tgt[0] = (in_target_one   > ONE) ? ONE : in_target_one;
  assign tgt[1] = (in_target_two   > ONE) ? ONE : in_target_two;
  assign tgt[2] = (in_target_three > ONE) ? ONE : in_target_three;

  always_comb begin
    any_diff = 1'b0;
    for (int i = 0; i < 3; i++) begin
      up_in[i]  = tgt[i] > lvl_r[i];
      mag_in[i] = up_in[i] ? (tgt[i] - lvl_r[i]) : (lvl_r[i] - tgt[i]);
      any_diff  = any_diff || (mag_in[i] != '0);
    end
  end

  assign start = accept && !hold_fixed_r && any_diff;

  tclf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .out_free (out_free),
    .ctrl     (ctrl)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.phase)
      ST_FRAC_MUL: begin
        mul_a = OW'(fade_rate_r);
        mul_b = OW'(elapsed_r);
      end
      ST_MOVE_MUL: begin
        mul_a = OW'(mag_r[ctrl.ch]);
        mul_b = OW'(frac_r);
      end
      ST_INT_MUL: begin
        mul_a = OW'(sum_r);
        mul_b = OW'(max_intensity_r);
      end
      ST_MIX_MUL: begin
        mul_a = OW'(lvl_r[ctrl.ch]);
        mul_b = OW'(color_r[ctrl.ch][ctrl.slot*COLOR_BITS +: COLOR_BITS]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  tclf_mul #(
    .AW (OW),
    .BW (OW)
  ) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Post-processing of the product for each phase.
  assign frac_full = prod[31:0] >> SH;
  assign step_ceil = {1'b0, prod[2*LEVEL_FRAC_BITS:LEVEL_FRAC_BITS]}
                   + (LW+1)'(|prod[LEVEL_FRAC_BITS-1:0]);
  assign lvl_sum   = (LW+2)'(lvl_r[0]) + (LW+2)'(lvl_r[1]) + (LW+2)'(lvl_r[2]);
  assign acc_nxt   = ((ctrl.ch == CH_FIRST) ? '0 : acc_r)
                   + ACW'(prod[COLOR_BITS+LEVEL_FRAC_BITS-1:0]);
  assign mix_hi    = acc_nxt[ACW-1:LEVEL_FRAC_BITS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_rate_r     <= 16'd256;
      max_intensity_r <= '0;
      color_r[0]      <= '1;
      color_r[1]      <= '0;
      color_r[2]      <= '0;
      hold_fixed_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FADE_RATE:     fade_rate_r     <= cfg_data[15:0];
        REG_MAX_INTENSITY: max_intensity_r <= cfg_data[15:0];
        REG_COLOR_ONE:     color_r[0]      <= cfg_data[CW-1:0];
        REG_COLOR_TWO:     color_r[1]      <= cfg_data[CW-1:0];
        REG_COLOR_THREE:   color_r[2]      <= cfg_data[CW-1:0];
        REG_HOLD_FIXED:    hold_fixed_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stored levels: cleared by reset, then moved by one step per channel in the apply phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        lvl_r[i] <= '0;
      end
    end else if (ctrl.phase == ST_MOVE_APPLY) begin
      lvl_r[ctrl.ch] <= up_r[ctrl.ch] ? (lvl_r[ctrl.ch] + step_r)
                                      : (lvl_r[ctrl.ch] - step_r);
    end
  end

  // Working registers of the sequence.
  always_ff @(posedge clk) begin
    if (start) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i] <= mag_in[i];
        up_r[i]  <= up_in[i];
      end
      elapsed_r <= in_elapsed;
    end
    case (ctrl.phase)
      ST_FRAC_SET: begin
        frac_r <= (frac_full > ONE_W) ? ONE : frac_full[LW-1:0];
      end
      ST_MOVE_STEP: begin
        step_r <= (step_ceil > {1'b0, mag_r[ctrl.ch]}) ? mag_r[ctrl.ch]
                                                       : step_ceil[LW-1:0];
      end
      ST_SUM: begin
        sum_r <= (lvl_sum > (LW+2)'(ONE)) ? ONE : lvl_sum[LW-1:0];
      end
      ST_INT_SET: begin
        int_r <= prod[LEVEL_FRAC_BITS +: 16];
      end
      ST_MIX_ACC: begin
        acc_r <= acc_nxt;
        if (ctrl.ch == CH_LAST) begin
          mix_r[ctrl.slot] <= (mix_hi > CMAX) ? CMAX[COLOR_BITS-1:0]
                                              : mix_hi[COLOR_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  // Output register: loaded when the sequence finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_int_r   <= int_r;
      out_red_r   <= mix_r[SLOT_RED];
      out_green_r <= mix_r[SLOT_GREEN];
      out_blue_r  <= mix_r[SLOT_BLUE];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_intensity = out_int_r;
  assign out_red       = out_red_r;
  assign out_green     = out_green_r;
  assign out_blue      = out_blue_r;

  // Levels never pass full scale, and a step never overshoots its distance.
  assign lvl_ok  = (lvl_r[0] <= ONE) && (lvl_r[1] <= ONE) && (lvl_r[2] <= ONE);
  assign step_ok = (ctrl.phase != ST_MOVE_APPLY) || (step_r <= mag_r[ctrl.ch]);

  // Levels never pass full scale, since targets are clamped and steps are bounded.
  `TCLF_ASSERT_NOW(a_level_range, lvl_ok, "level above full scale")
  // A level step never overshoots the remaining distance.
  `TCLF_ASSERT_NOW(a_step_bound, step_ok, "step exceeds distance")
  // An item that causes no result leaves the block idle.
  `TCLF_ASSERT_NEXT(a_skip_idle, accept && !start, ctrl.phase == ST_IDLE, "skipped item started")
  // A finished sequence always presents its result next cycle.
  `TCLF_ASSERT_NEXT(a_done_out, load_out, out_valid && !in_stall, "result not presented")

endmodule

// File: verif/tb_three_channel_light_fader.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-channel light fader top level.
// Depends on tclf_pkg and three_channel_light_fader; a built-in fade and color
// predictor checks every result item in order.
module tb_three_channel_light_fader;
  import tclf_pkg::*;

  localparam int          HALF_PERIOD    = 4;
  localparam int          SETTLE_CYCLES  = 40;
  localparam int          LONG_HOLD      = 300;
  localparam int          TIMEOUT_CYCLES = 1_000_000;
  localparam int          MAX_PRINTS     = 40;
  localparam logic [63:0] ONE            = 64'd1 << 16;
  localparam logic [2:0]  REG_SPARE_LO   = REG_HOLD_FIXED + 3'd1;
  localparam logic [2:0]  REG_SPARE_HI   = 3'd7;

  typedef struct {
    logic [16:0] t1;
    logic [16:0] t2;
    logic [16:0] t3;
    logic [15:0] el;
  } tick_t;

  typedef struct {
    logic [15:0] intensity;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } lit_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [16:0] in_target_one   = '0;
  logic [16:0] in_target_two   = '0;
  logic [16:0] in_target_three = '0;
  logic [15:0] in_elapsed      = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [15:0] out_intensity;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index       = '0;
  logic [23:0] cfg_data        = '0;

  // Pending input items and the lighting frames they are expected to produce.
  tick_t tick_q[$];
  lit_t  lit_q[$];

  // Predictor state: the three levels and the register file.
  logic [16:0] lvl[3]    = '{17'd0, 17'd0, 17'd0};
  logic [15:0] rate_q88  = 16'd256;
  logic [15:0] full_scale = 16'd0;
  logic [23:0] tint[3]   = '{24'hFFFFFF, 24'h000000, 24'h000000};
  logic        frozen    = 1'b0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned stall_left    = 0;
  logic        in_taken      = 1'b0;

  int unsigned ticks_taken    = 0;
  int unsigned frames_checked = 0;
  int unsigned regs_written   = 0;
  int unsigned mismatches     = 0;

  three_channel_light_fader dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_target_one   (in_target_one),
    .in_target_two   (in_target_two),
    .in_target_three (in_target_three),
    .in_elapsed      (in_elapsed),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_intensity   (out_intensity),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // Targets above full scale saturate to one.
  function automatic logic [16:0] clamp_level(logic [16:0] t);
    return (t > ONE) ? ONE[16:0] : t;
  endfunction

  // Move one level toward its target by the fraction, rounding the step up.
  function automatic logic [16:0] step_toward(logic [16:0] now, logic [16:0] tgt,
                                              logic [63:0] frac);
    logic [63:0] mag;
    logic [63:0] stp;
    if (tgt == now) return now;
    mag = (tgt > now) ? 64'(tgt - now) : 64'(now - tgt);
    stp = (mag * frac + (ONE - 64'd1)) >> 16;
    if (stp > mag) stp = mag;
    return (tgt > now) ? now + stp[16:0] : now - stp[16:0];
  endfunction

  // Weighted sum of one color slot over the three channels, saturated.
  function automatic logic [7:0] blend(int slot);
    logic [63:0] acc;
    acc = '0;
    for (int c = 0; c < 3; c++) begin
      acc = acc + ((tint[c] >> (slot * 8)) & 24'hFF) * lvl[c];
    end
    acc = acc >> 16;
    return (acc > 64'd255) ? 8'hFF : acc[7:0];
  endfunction

  // Advance the predicted levels for one item; true when a frame is due.
  function automatic bit fade_tick(input tick_t t, output lit_t f);
    logic [16:0] tg[3];
    logic [63:0] frac;
    logic [63:0] sum;
    f = '{default: '0};
    if (frozen) return 1'b0;
    tg[0] = clamp_level(t.t1);
    tg[1] = clamp_level(t.t2);
    tg[2] = clamp_level(t.t3);
    if (tg[0] == lvl[0] && tg[1] == lvl[1] && tg[2] == lvl[2]) return 1'b0;
    frac = (64'(rate_q88) * 64'(t.el)) >> 8;
    if (frac > ONE) frac = ONE;
    for (int c = 0; c < 3; c++) begin
      lvl[c] = step_toward(lvl[c], tg[c], frac);
    end
    sum = 64'(lvl[0]) + 64'(lvl[1]) + 64'(lvl[2]);
    if (sum > ONE) sum = ONE;
    f.intensity = 16'((sum * 64'(full_scale)) >> 16);
    f.red       = blend(SLOT_RED);
    f.green     = blend(SLOT_GREEN);
    f.blue      = blend(SLOT_BLUE);
    return 1'b1;
  endfunction

  // Mirror a register write; indexes past the list are dropped.
  function automatic void apply_register(logic [2:0] idx, logic [23:0] val);
    case (idx)
      REG_FADE_RATE:     rate_q88   = val[15:0];
      REG_MAX_INTENSITY: full_scale = val[15:0];
      REG_COLOR_ONE:     tint[0]    = val;
      REG_COLOR_TWO:     tint[1]    = val;
      REG_COLOR_THREE:   tint[2]    = val;
      REG_HOLD_FIXED:    frozen     = val[0];
      default: ;
    endcase
  endfunction

  task automatic note_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= MAX_PRINTS) begin
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  // Input driver: holds a stalled item, otherwise offers the next one or idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_taken) begin
      // The current item has not been taken yet, so it stays put.
    end else if (tick_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      tick_t t;
      t = tick_q.pop_front();
      in_valid        <= 1'b1;
      in_target_one   <= t.t1;
      in_target_two   <= t.t2;
      in_target_three <= t.t3;
      in_elapsed      <= t.el;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result receiver: random stalls, plus a long hold-off when one is requested.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (hold_requests != hold_served) begin
      hold_served++;
      stall_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: track register writes, predict taken items, check result items.
  always @(posedge clk) begin
    tick_t t;
    lit_t  f;
    lit_t  want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        apply_register(cfg_index, cfg_data);
        regs_written++;
      end
      if (in_valid && !in_stall) begin
        t = '{in_target_one, in_target_two, in_target_three, in_elapsed};
        ticks_taken++;
        if (fade_tick(t, f)) lit_q.push_back(f);
      end
      if (out_valid && !out_stall) begin
        if (lit_q.size() == 0) begin
          note_mismatch("unexpected result item", 1, 0);
        end else begin
          want = lit_q.pop_front();
          frames_checked++;
          if (out_intensity !== want.intensity)
            note_mismatch("intensity", out_intensity, want.intensity);
          if (out_red !== want.red) note_mismatch("red", out_red, want.red);
          if (out_green !== want.green) note_mismatch("green", out_green, want.green);
          if (out_blue !== want.blue) note_mismatch("blue", out_blue, want.blue);
        end
      end
    end
  end

  task automatic push_tick(logic [16:0] t1, logic [16:0] t2, logic [16:0] t3,
                           logic [15:0] el);
    tick_q.push_back('{t1, t2, t3, el});
  endtask

  // Wait until every item is taken and every frame has arrived, then let
  // the block finish any item that produced no result.
  task automatic settle();
    while (tick_q.size() != 0 || in_valid || lit_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [16:0] pick_target();
    case ($urandom_range(7))
      0:       return 17'd0;
      1:       return ONE[16:0];
      2:       return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [15:0] pick_elapsed();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 2048));
    endcase
  endfunction

  // Mostly fades: one target set held over several ticks so the levels
  // creep toward it and settle; the rest is raw noise.
  task automatic queue_fades(int unsigned n);
    tick_t       t;
    int unsigned made;
    int unsigned run;
    made = 0;
    while (made < n) begin
      if ($urandom_range(9) == 0) begin
        t = '{17'($urandom), 17'($urandom), 17'($urandom), 16'($urandom)};
        tick_q.push_back(t);
        made++;
      end else begin
        t.t1 = pick_target();
        t.t2 = pick_target();
        t.t3 = pick_target();
        run  = $urandom_range(1, 10);
        repeat (run) begin
          t.el = pick_elapsed();
          tick_q.push_back(t);
          made++;
        end
      end
    end
  endtask

  // New register settings; unused upper data bits carry random junk.
  task automatic shuffle_lighting();
    logic [15:0] rate;
    logic [15:0] scale;
    case ($urandom_range(5))
      0:       rate = 16'd0;
      1:       rate = 16'hFFFF;
      default: rate = 16'($urandom_range(16, 4096));
    endcase
    case ($urandom_range(3))
      0:       scale = 16'd0;
      1:       scale = 16'hFFFF;
      default: scale = 16'($urandom);
    endcase
    write_reg(REG_FADE_RATE, {8'($urandom), rate});
    write_reg(REG_MAX_INTENSITY, {8'($urandom), scale});
    write_reg(REG_COLOR_ONE, ($urandom_range(3) == 0) ? 24'hFFFFFF : 24'($urandom));
    write_reg(REG_COLOR_TWO, ($urandom_range(3) == 0) ? 24'h000000 : 24'($urandom));
    write_reg(REG_COLOR_THREE, 24'($urandom));
    write_reg(REG_HOLD_FIXED, {23'($urandom), 1'b0});
  endtask

  // Stimulus: directed corners, then random phases under three idle mixes.
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: no change, zero time step, over-range targets, mixed edges.
    push_tick(17'd0, 17'd0, 17'd0, 16'd0);
    push_tick(ONE[16:0], ONE[16:0], ONE[16:0], 16'd0);
    push_tick(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 16'hFFFF);
    push_tick(ONE[16:0], 17'd0, 17'd1, 16'hFFFF);
    push_tick(17'd0, ONE[16:0], 17'd65535, 16'd1);
    settle();

    // Fastest fade and full-scale colors: jumps straight to target, saturation.
    write_reg(REG_FADE_RATE, 24'h00FFFF);
    write_reg(REG_MAX_INTENSITY, 24'h00FFFF);
    write_reg(REG_COLOR_ONE, 24'hFFFFFF);
    write_reg(REG_COLOR_TWO, 24'hFFFFFF);
    write_reg(REG_COLOR_THREE, 24'hFFFFFF);
    push_tick(ONE[16:0], ONE[16:0], ONE[16:0], 16'hFFFF);
    push_tick(17'd0, 17'd0, 17'd0, 16'hFFFF);
    push_tick(17'd1, 17'd1, 17'd1, 16'd1);
    push_tick(17'd1, 17'd1, 17'd1, 16'd1);
    push_tick(ONE[16:0], 17'd0, ONE[16:0], 16'd256);
    settle();

    // Zero fade rate: a frame is still produced but no level moves.
    write_reg(REG_FADE_RATE, 24'hAB0000);
    write_reg(REG_SPARE_LO, 24'($urandom));
    write_reg(REG_SPARE_HI, 24'($urandom));
    write_reg(REG_COLOR_TWO, 24'h123456);
    push_tick(17'd100, 17'd200, 17'd300, 16'hFFFF);
    push_tick(17'h10000, 17'd0, 17'h1FFFF, 16'h8000);
    settle();

    // Hold mode: items are swallowed, then released with junk in the upper bits.
    write_reg(REG_HOLD_FIXED, 24'h000001);
    write_reg(REG_FADE_RATE, 24'h000100);
    push_tick(ONE[16:0], 17'd5, 17'd7, 16'hFFFF);
    push_tick(17'd0, ONE[16:0], 17'd0, 16'h0100);
    settle();
    write_reg(REG_HOLD_FIXED, 24'hFFFFFE);
    push_tick(ONE[16:0], 17'd5, 17'd7, 16'h4000);
    push_tick(ONE[16:0], 17'd5, 17'd7, 16'h4000);
    settle();

    // Sender idles a little, receiver a lot; one long receiver hold-off.
    send_idle_pct = 21;
    recv_idle_pct = 59;
    shuffle_lighting();
    queue_fades(305);
    repeat (20) @(posedge clk);
    hold_requests++;
    settle();
    shuffle_lighting();
    queue_fades(305);
    settle();

    // A short frozen stretch between random phases.
    write_reg(REG_HOLD_FIXED, 24'h000001);
    queue_fades(20);
    settle();

    // Roles reversed.
    send_idle_pct = 59;
    recv_idle_pct = 21;
    shuffle_lighting();
    queue_fades(305);
    settle();
    shuffle_lighting();
    queue_fades(305);
    settle();

    // No idling at all, with the rate at both extremes.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    shuffle_lighting();
    write_reg(REG_FADE_RATE, 24'h00FFFF);
    queue_fades(150);
    settle();
    write_reg(REG_FADE_RATE, 24'h000000);
    queue_fades(30);
    settle();
    shuffle_lighting();
    queue_fades(415);
    settle();

    $display("Covered %0d input items and %0d checked result items over %0d register writes,",
             ticks_taken, frames_checked, regs_written);
    $display("including hold mode, saturation, long output back-pressure and idle mixes.");
    if (mismatches == 0 && lit_q.size() == 0) begin
      $display("[three_channel_light_fader] OK");
    end else begin
      $display("[three_channel_light_fader] ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
    $display("Timeout with %0d result items still expected.", lit_q.size());
    $display("[three_channel_light_fader] ERROR");
    $finish;
  end

endmodule
